[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define CRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define CRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/crt_pkg.sv]
// shared types, constants and command codes of the crt reconstruction block
package crt_pkg;

    localparam int MAX_ENTRIES_DEF  = 128;
    localparam int MODULUS_BITS_DEF = 16;
    localparam int WIDE_BITS        = 64;
    localparam int POS_BITS         = 8;

    typedef struct packed {
        logic [15:0] period;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [63:0] earliest_time;
        logic [63:0] modulus_product;
        logic        overflow;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_DIV,
        OP_STORE,
        OP_POS_STEP,
        OP_PROD_INIT,
        OP_READ,
        OP_LMUL,
        OP_PROD_TAKE,
        OP_SUM_INIT,
        OP_NEXT,
        OP_TAKE_MI,
        OP_TAKE_BASE,
        OP_SMUL,
        OP_SET_ACC,
        OP_SET_B,
        OP_SET_K,
        OP_ACCUM,
        OP_EMIT
    } t_op;

    // dividend source of the serial divider
    typedef enum logic [1:0] {
        DS_POS,
        DS_TOTAL,
        DS_MI,
        DS_PP
    } t_dsel;

    // operand pair of the narrow multiplier
    typedef enum logic [1:0] {
        MS_ACC_B,
        MS_B_B,
        MS_A_ACC
    } t_msel;

    // operand pair of the serial wide multiplier
    typedef enum logic {
        LS_TOTAL,
        LS_MI
    } t_lsel;

    typedef struct packed {
        t_op   op;
        t_dsel dsel;
        t_msel msel;
        t_lsel lsel;
    } t_cmd;

    localparam t_cmd CMD_NONE = '{op: OP_NONE, dsel: DS_POS, msel: MS_ACC_B, lsel: LS_TOTAL};

    typedef struct packed {
        logic zero_period;
        logic table_full;
        logic last;
        logic idx_end;
        logic mm_lt2;
        logic ovf;
        logic exp_bit;
        logic k_end;
        logic div_done;
        logic mul_done;
        logic out_full;
    } t_stat;

endpackage

[src/crt_reconstruct_unit.sv]
// top level of the crt reconstruction block: controller, datapath and checks
// one beat at a time: a stored period takes one 64-step division, a skipped one none
// a last beat adds a product pass, one serial multiplication per stored modulus, and a
// sum pass per modulus of two or more, skipped on overflow, run mainly on the shared
// 64-step serial divider; the result then waits in an output register
// synchronous active-low reset empties the list, drops the output valid and leaves the tables as is
`include "assert_macros.svh"

module crt_reconstruct_unit #(
    parameter int MAX_ENTRIES  = crt_pkg::MAX_ENTRIES_DEF,
    parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  crt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output crt_pkg::t_out o_out_data
);
    import crt_pkg::*;

    // command and status between the sequencer and the datapath
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;
    logic  w_accept;

    // an input beat is taken only while the sequencer sits idle
    assign o_in_stall = !w_ready;
    assign w_accept   = i_in_valid && w_ready;

    crt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_ready  (w_ready)
    );

    // tables, wide registers, serial multiplier and divider
    crt_dp #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MODULUS_BITS (MODULUS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_stat      (w_stat)
    );

    // an overflowing product forces the time field to zero
    `CRT_ASSERT_IMP(a_ovf_time_zero, i_clk, i_rst_n, o_out_valid && o_out_data.overflow, o_out_data.earliest_time == 64'd0, "overflow with nonzero time")
    // a result beat appears only after an emit command
    `CRT_ASSERT_IMP(a_emit_source, i_clk, i_rst_n, $rose(o_out_valid), $past(w_cmd.op == OP_EMIT), "result without emit")
    // no datapath command runs while the input side is open
    `CRT_ASSERT_IMP(a_busy_stalls, i_clk, i_rst_n, w_cmd.op != OP_NONE, o_in_stall, "command issued while ready")

endmodule

[src/crt_div.sv]
// restoring serial divider, one quotient bit per cycle
module crt_div #(
    parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [crt_pkg::WIDE_BITS-1:0] i_dividend,
    input  logic [MODULUS_BITS-1:0]       i_divisor,
    output logic                          o_done,
    output logic [crt_pkg::WIDE_BITS-1:0] o_quot,
    output logic [MODULUS_BITS-1:0]       o_rem
);
    import crt_pkg::*;

    localparam int CNT_W = $clog2(WIDE_BITS + 1);

    logic [WIDE_BITS-1:0]    r_dvd;
    logic [MODULUS_BITS-1:0] r_rem;
    logic [MODULUS_BITS-1:0] r_dsr;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic [MODULUS_BITS:0]   trial;
    logic [MODULUS_BITS:0]   diff;
    logic                    fits;

    assign trial = {r_rem, r_dvd[WIDE_BITS-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign fits  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(WIDE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[MODULUS_BITS-1:0] : trial[MODULUS_BITS-1:0];
            r_dvd <= {r_dvd[WIDE_BITS-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule

[src/crt_dp.sv]
// datapath: tables, product and sum registers, multipliers and the divider
module crt_dp #(
    parameter int MAX_ENTRIES  = crt_pkg::MAX_ENTRIES_DEF,
    parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  crt_pkg::t_in  i_in_data,
    input  crt_pkg::t_cmd i_cmd,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output crt_pkg::t_out o_out_data,
    output crt_pkg::t_stat o_stat
);
    import crt_pkg::*;

    localparam int MB   = MODULUS_BITS;
    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int KW   = $clog2(MB + 1);
    localparam int XW   = $clog2(MB);
    localparam int PW   = 2 * MB;
    localparam int WB   = WIDE_BITS;

    logic [2*MB-1:0] mem [MAX_ENTRIES];

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [POS_BITS-1:0] r_pos;
    logic                r_last;
    logic [MB-1:0]       r_mm;
    logic [MB-1:0]       r_a;
    logic [WB-1:0]       r_total;
    logic                r_ovf;
    logic [WB-1:0]       r_x;
    logic [WB-1:0]       r_mi;
    logic [MB-1:0]       r_acc;
    logic [MB-1:0]       r_b;
    logic [MB-1:0]       r_kv;
    logic [KW-1:0]       r_k;
    logic [PW-1:0]       r_pp;
    logic [WB-1:0]       r_mcand;
    logic [MB-1:0]       r_mplier;
    logic [WB+MB-1:0]    r_prod;
    logic [KW-1:0]       r_mcnt;
    logic                r_mbusy;
    logic                r_mdone;
    logic                r_out_valid;
    t_out                r_out;

    logic [WB-1:0] div_dvd;
    logic          div_done;
    logic [WB-1:0] div_quot;
    logic [MB-1:0] div_rem;
    logic [MB-1:0] residue;
    logic [MB-1:0] sm_a;
    logic [MB-1:0] sm_b;
    logic [WB:0]   m_sum;
    logic [WB-1:0] gap;
    logic [WB-1:0] prod_lo;
    logic [MB-1:0] exp_val;

    always_comb begin
        unique case (i_cmd.dsel)
            DS_POS:   div_dvd = WB'(r_pos);
            DS_TOTAL: div_dvd = r_total;
            DS_MI:    div_dvd = r_mi;
            DS_PP:    div_dvd = WB'(r_pp);
            default:  div_dvd = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.msel)
            MS_ACC_B: begin
                sm_a = r_acc;
                sm_b = r_b;
            end
            MS_B_B: begin
                sm_a = r_b;
                sm_b = r_b;
            end
            MS_A_ACC: begin
                sm_a = r_a;
                sm_b = r_acc;
            end
            default: begin
                sm_a = '0;
                sm_b = '0;
            end
        endcase
    end

    crt_div #(
        .MODULUS_BITS(MB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV),
        .i_dividend (div_dvd),
        .i_divisor  (r_mm),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign residue = (div_rem == '0) ? '0 : (r_mm - div_rem);
    assign m_sum   = {1'b0, r_prod[WB+MB-1:MB]} + (r_mplier[0] ? {1'b0, r_mcand} : '0);
    assign prod_lo = r_prod[WB-1:0];
    assign gap     = r_total - prod_lo;
    assign exp_val = r_mm - MB'(2);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_mbusy     <= 1'b0;
            r_mdone     <= 1'b0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_LMUL) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + KW'(1);
                if (r_mcnt == KW'(MB - 1)) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
            unique case (i_cmd.op)
                OP_STORE: begin
                    r_count <= r_count + CW'(1);
                    r_pos   <= r_pos + POS_BITS'(1);
                end
                OP_POS_STEP:  r_pos <= r_pos + POS_BITS'(1);
                OP_PROD_INIT: r_idx <= '0;
                OP_SUM_INIT:  r_idx <= '0;
                OP_PROD_TAKE: r_idx <= r_idx + CW'(1);
                OP_NEXT:      r_idx <= r_idx + CW'(1);
                OP_ACCUM:     r_idx <= r_idx + CW'(1);
                OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_count     <= '0;
                    r_pos       <= '0;
                end
                default: ;
            endcase
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_STORE) begin
            mem[r_count[AW-1:0]] <= {r_mm, residue};
        end
        if (i_cmd.op == OP_READ) begin
            {r_mm, r_a} <= mem[r_idx[AW-1:0]];
        end else if (i_accept) begin
            r_mm <= MB'(i_in_data.period);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_last <= i_in_data.last;
        end
        if (i_cmd.op == OP_LMUL) begin
            r_prod <= '0;
            unique case (i_cmd.lsel)
                LS_TOTAL: begin
                    r_mcand  <= r_total;
                    r_mplier <= r_mm;
                end
                LS_MI: begin
                    r_mcand  <= r_mi;
                    r_mplier <= r_kv;
                end
                default: ;
            endcase
        end else if (r_mbusy) begin
            r_prod   <= {m_sum, r_prod[MB-1:1]};
            r_mplier <= r_mplier >> 1;
        end
        unique case (i_cmd.op)
            OP_PROD_INIT: begin
                r_total <= WB'(1);
                r_ovf   <= 1'b0;
            end
            OP_PROD_TAKE: begin
                r_total <= prod_lo;
                r_ovf   <= r_ovf | (|r_prod[WB+MB-1:WB]);
            end
            OP_SUM_INIT:  r_x <= '0;
            OP_TAKE_MI:   r_mi <= div_quot;
            OP_TAKE_BASE: begin
                r_b   <= div_rem;
                r_acc <= MB'(1);
                r_k   <= '0;
            end
            OP_SMUL:    r_pp <= {{MB{1'b0}}, sm_a} * {{MB{1'b0}}, sm_b};
            OP_SET_ACC: r_acc <= div_rem;
            OP_SET_B: begin
                r_b <= div_rem;
                r_k <= r_k + KW'(1);
            end
            OP_SET_K:   r_kv <= div_rem;
            OP_ACCUM:   r_x <= (r_x >= gap) ? (r_x - gap) : (r_x + prod_lo);
            OP_EMIT: begin
                r_out.earliest_time   <= r_ovf ? '0 : r_x;
                r_out.modulus_product <= r_total;
                r_out.overflow        <= r_ovf;
            end
            default: ;
        endcase
    end

    assign o_stat.zero_period = (r_mm == '0);
    assign o_stat.table_full  = (r_count == CW'(MAX_ENTRIES));
    assign o_stat.last        = r_last;
    assign o_stat.idx_end     = (r_idx == r_count);
    assign o_stat.mm_lt2      = (r_mm < MB'(2));
    assign o_stat.ovf         = r_ovf;
    assign o_stat.exp_bit     = exp_val[r_k[XW-1:0]];
    assign o_stat.k_end       = (r_k == KW'(MB));
    assign o_stat.div_done    = div_done;
    assign o_stat.mul_done    = r_mdone;
    assign o_stat.out_full    = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[src/crt_ctrl.sv]
// controller: sequences loading, the product pass and the sum pass, then emits the result
module crt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  crt_pkg::t_stat i_stat,
    output crt_pkg::t_cmd  o_cmd,
    output logic           o_ready
);
    import crt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_RES_W, S_AFTER,
        S_P_SETTLE, S_P_TEST, S_P_RD, S_P_MW,
        S_S_SETTLE, S_S_TEST, S_S_RD, S_S_CHK, S_S_D1, S_S_D2A, S_S_D2,
        S_F_SETTLE, S_F_TEST, S_F_AW1, S_F_AW2, S_F_BMUL, S_F_BW1, S_F_BW2,
        S_K_W1, S_K_W2, S_K_MUL, S_K_MW,
        S_EMIT, S_DONE
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_NONE;
            r_ready <= 1'b1;
        end else begin
            r_cmd <= CMD_NONE;
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_ready <= 1'b0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!i_stat.zero_period && !i_stat.table_full) begin
                        r_cmd.op   <= OP_DIV;
                        r_cmd.dsel <= DS_POS;
                        r_state    <= S_RES_W;
                    end else begin
                        r_cmd.op <= OP_POS_STEP;
                        r_state  <= S_AFTER;
                    end
                end
                S_RES_W: begin
                    if (i_stat.div_done) begin
                        r_cmd.op <= OP_STORE;
                        r_state  <= S_AFTER;
                    end
                end
                S_AFTER: begin
                    if (i_stat.last) begin
                        r_cmd.op <= OP_PROD_INIT;
                        r_state  <= S_P_SETTLE;
                    end else begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_P_SETTLE: r_state <= S_P_TEST;
                S_P_TEST: begin
                    if (i_stat.idx_end) begin
                        r_cmd.op <= OP_SUM_INIT;
                        r_state  <= S_S_SETTLE;
                    end else begin
                        r_cmd.op <= OP_READ;
                        r_state  <= S_P_RD;
                    end
                end
                S_P_RD: begin
                    r_cmd.op   <= OP_LMUL;
                    r_cmd.lsel <= LS_TOTAL;
                    r_state    <= S_P_MW;
                end
                S_P_MW: begin
                    if (i_stat.mul_done) begin
                        r_cmd.op <= OP_PROD_TAKE;
                        r_state  <= S_P_SETTLE;
                    end
                end
                S_S_SETTLE: r_state <= S_S_TEST;
                S_S_TEST: begin
                    if (i_stat.ovf || i_stat.idx_end) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_cmd.op <= OP_READ;
                        r_state  <= S_S_RD;
                    end
                end
                S_S_RD: r_state <= S_S_CHK;
                S_S_CHK: begin
                    if (i_stat.mm_lt2) begin
                        r_cmd.op <= OP_NEXT;
                        r_state  <= S_S_SETTLE;
                    end else begin
                        r_cmd.op   <= OP_DIV;
                        r_cmd.dsel <= DS_TOTAL;
                        r_state    <= S_S_D1;
                    end
                end
                S_S_D1: begin
                    if (i_stat.div_done) begin
                        r_cmd.op <= OP_TAKE_MI;
                        r_state  <= S_S_D2A;
                    end
                end
                S_S_D2A: begin
                    r_cmd.op   <= OP_DIV;
                    r_cmd.dsel <= DS_MI;
                    r_state    <= S_S_D2;
                end
                S_S_D2: begin
                    if (i_stat.div_done) begin
                        r_cmd.op <= OP_TAKE_BASE;
                        r_state  <= S_F_SETTLE;
                    end
                end
                S_F_SETTLE: r_state <= S_F_TEST;
                S_F_TEST: begin
                    r_cmd.op <= OP_SMUL;
                    priority if (i_stat.k_end) begin
                        r_cmd.msel <= MS_A_ACC;
                        r_state    <= S_K_W1;
                    end else if (i_stat.exp_bit) begin
                        r_cmd.msel <= MS_ACC_B;
                        r_state    <= S_F_AW1;
                    end else begin
                        r_cmd.msel <= MS_B_B;
                        r_state    <= S_F_BW1;
                    end
                end
                S_F_AW1: begin
                    r_cmd.op   <= OP_DIV;
                    r_cmd.dsel <= DS_PP;
                    r_state    <= S_F_AW2;
                end
                S_F_AW2: begin
                    if (i_stat.div_done) begin
                        r_cmd.op <= OP_SET_ACC;
                        r_state  <= S_F_BMUL;
                    end
                end
                S_F_BMUL: begin
                    r_cmd.op   <= OP_SMUL;
                    r_cmd.msel <= MS_B_B;
                    r_state    <= S_F_BW1;
                end
                S_F_BW1: begin
                    r_cmd.op   <= OP_DIV;
                    r_cmd.dsel <= DS_PP;
                    r_state    <= S_F_BW2;
                end
                S_F_BW2: begin
                    if (i_stat.div_done) begin
                        r_cmd.op <= OP_SET_B;
                        r_state  <= S_F_SETTLE;
                    end
                end
                S_K_W1: begin
                    r_cmd.op   <= OP_DIV;
                    r_cmd.dsel <= DS_PP;
                    r_state    <= S_K_W2;
                end
                S_K_W2: begin
                    if (i_stat.div_done) begin
                        r_cmd.op <= OP_SET_K;
                        r_state  <= S_K_MUL;
                    end
                end
                S_K_MUL: begin
                    r_cmd.op   <= OP_LMUL;
                    r_cmd.lsel <= LS_MI;
                    r_state    <= S_K_MW;
                end
                S_K_MW: begin
                    if (i_stat.mul_done) begin
                        r_cmd.op <= OP_ACCUM;
                        r_state  <= S_S_SETTLE;
                    end
                end
                S_EMIT: begin
                    if (!i_stat.out_full) begin
                        r_cmd.op <= OP_EMIT;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_ready <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd   = r_cmd;
    assign o_ready = r_ready;

endmodule

[tb/crt_checker.sv]
// channel monitor, earliest-time predictor and result comparison for the crt block
`timescale 1ns / 1ps

module crt_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  crt_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  crt_pkg::t_out i_out_data,
    output int            o_mismatches,
    output int            o_pending,
    output int            o_results_seen
);
    import crt_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam int EXP_BITS    = MODULUS_BITS_DEF;

    logic [15:0]         moduli[TABLE_DEPTH];
    logic [15:0]         residues[TABLE_DEPTH];
    int                  n_stored;
    logic [POS_BITS-1:0] list_pos;
    t_out                solutions_due[$];

    // base^(m-2) mod m, exponent scanned over a fixed width
    function automatic logic [63:0] fermat_inv(logic [63:0] base, logic [63:0] m);
        logic [63:0] ex;
        logic [63:0] acc;
        logic [63:0] b;
        ex  = m - 2;
        acc = 1 % m;
        b   = base % m;
        for (int k = 0; k < EXP_BITS; k++) begin
            if (ex[k])
                acc = (acc * b) % m;
            b = (b * b) % m;
        end
        return acc;
    endfunction

    function automatic t_out solve_list();
        t_out        r;
        logic [63:0] prod;
        logic [63:0] x;
        logic [63:0] mm;
        logic [63:0] mi;
        logic [63:0] kk;
        logic [63:0] term;
        logic        ovf;
        prod = 64'd1;
        x    = 64'd0;
        ovf  = 1'b0;
        for (int i = 0; i < n_stored; i++) begin
            mm = moduli[i];
            if (mm != 0 && prod > 64'hFFFF_FFFF_FFFF_FFFF / mm)
                ovf = 1'b1;
            prod = prod * mm;
        end
        if (!ovf) begin
            for (int i = 0; i < n_stored; i++) begin
                mm = moduli[i];
                if (mm < 2)
                    continue;
                mi   = prod / mm;
                kk   = (64'(residues[i]) * fermat_inv(mi % mm, mm)) % mm;
                term = mi * kk;
                x    = (x >= prod - term) ? x - (prod - term) : x + term;
            end
        end
        r.earliest_time   = ovf ? 64'd0 : x;
        r.modulus_product = prod;
        r.overflow        = ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            n_stored = 0;
            list_pos = '0;
            solutions_due.delete();
            o_mismatches   <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (solutions_due.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: unexpected result beat %p", $time, i_out_data);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = solutions_due.pop_front();
                    if (want.earliest_time != i_out_data.earliest_time
                        || want.modulus_product != i_out_data.modulus_product
                        || want.overflow != i_out_data.overflow) begin
                        if (o_mismatches < 10)
                            $display("%0t: time exp %0d got %0d, product exp %0d got %0d, ovf exp %0b got %0b",
                                $time, want.earliest_time, i_out_data.earliest_time,
                                want.modulus_product, i_out_data.modulus_product,
                                want.overflow, i_out_data.overflow);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.period != 0 && n_stored < TABLE_DEPTH) begin
                    moduli[n_stored]   = i_in_data.period;
                    residues[n_stored] = 16'((i_in_data.period - (16'(list_pos) % i_in_data.period))
                                             % i_in_data.period);
                    n_stored++;
                end
                list_pos = list_pos + 1'b1;
                if (i_in_data.last) begin
                    solutions_due = {solutions_due, solve_list()};
                    n_stored = 0;
                    list_pos = '0;
                end
            end
        end
        o_pending <= solutions_due.size();
    end

endmodule

[tb/tb_top.sv]
// stimulus, idling phases and verdict for the crt reconstruction block
`timescale 1ns / 1ps

module tb_top;
    import crt_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    int mismatches;
    int pending;
    int results_seen;
    int lists_sent;
    int beats_sent;
    int send_idle_pct;
    int recv_stall_pct;

    // mostly primes so the fermat inverse is meaningful, plus the largest 16-bit primes
    int primes[30] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61,
                       67, 71, 73, 79, 83, 89, 97, 65521, 65519, 65497, 65479, 65449};

    always #1 i_clk = ~i_clk;

    crt_reconstruct_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    crt_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_data     (o_out_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // safety net: far beyond the slowest legal run
    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one beat; an optional random gap first, then hold until the block takes it
    task automatic send_beat(logic [15:0] period, logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_in_data.period  <= period;
        i_in_data.last    <= last;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        if (last)
            lists_sent++;
    endtask

    task automatic go_quiet();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [15:0] pick_period();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 16'(primes[$urandom_range(0, 24)]);
        else if (sel < 70)
            return 16'(primes[$urandom_range(25, 29)]);
        else if (sel < 82)
            return 16'd0;
        else if (sel < 86)
            return 16'd1;
        else
            return 16'($urandom());
    endfunction

    task automatic send_random_list();
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
            send_beat(pick_period(), i == len - 1);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        lists_sent     = 0;
        beats_sent     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, one skipped position
        send_beat(16'd0, 1'b1);
        // single largest period
        send_beat(16'hFFFF, 1'b1);
        // classic bus list with skipped positions
        send_beat(16'd7, 1'b0);
        send_beat(16'd13, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'd59, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'd31, 1'b0);
        send_beat(16'd19, 1'b1);
        // modulus one mixed in
        send_beat(16'd1, 1'b0);
        send_beat(16'd5, 1'b0);
        send_beat(16'd1, 1'b1);
        // non-coprime, non-prime moduli
        send_beat(16'd6, 1'b0);
        send_beat(16'd4, 1'b1);
        // product overflow with the largest primes
        for (int i = 0; i < 5; i++)
            send_beat(16'd65521, i == 4);
        // alternating bit patterns in the period
        send_beat(16'hAAAA, 1'b0);
        send_beat(16'h5555, 1'b1);
        go_quiet();

        // table full: the moduli after 128 ones are dropped
        for (int i = 0; i < 130; i++)
            send_beat(i < 128 ? 16'd1 : 16'd3, i == 129);
        // position wrap: residues come from the 8-bit position
        for (int i = 0; i < 258; i++)
            send_beat(i == 254 ? 16'd7 : i == 256 ? 16'd11 : i == 257 ? 16'd13 : 16'd0,
                      i == 257);
        go_quiet();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < 60; n++) begin
                send_random_list();
                // drain now and then so a list starts on an empty block
                if ($urandom_range(0, 24) == 0)
                    go_quiet();
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);

        $display("covered %0d beats in %0d lists: skips, ones, table full, wrap, overflow",
                 beats_sent, lists_sent);
        $display("%0d result beats compared, %0d mismatching", results_seen, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
